// ===== rtl/rmed_pkg.sv =====
// shared field widths and payload types for the running median block
package rmed_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int COUNT_W  = 11;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEDIAN_W-1:0] median_type;
   typedef logic        [COUNT_W-1:0]  count_type;

endpackage

// ===== rtl/rmed_ram.sv =====
// generic single write port, single read port ram with registered read data
module rmed_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/running_median_sorted_insert.sv =====
// running median by sorted insertion into a single ram
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   req     | req_valid, req_stall, req_sample_value      | in
//   rsp     | rsp_valid, rsp_stall, rsp_median_doubled,   | out
//           | rsp_sample_count, rsp_rejected_full         |
//
// with samples held, the insertion scan walks down the store one entry a cycle
// through the ram's single read port, shifting each larger or equal entry up
// one place; two reads then fetch the middle pair. a full or empty store skips
// the scan and goes straight to the two reads.
// reset empties the store (count to zero) at once; no clearing pass is needed.
// req_stall is high while an item is in progress; a stalled result is held in
// the output register while the next item is taken and worked on.
module running_median_sorted_insert
   import rmed_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  sample_type req_sample_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output median_type rsp_median_doubled,
   output count_type  rsp_sample_count,
   output logic       rsp_rejected_full
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PUT  = 3'd2;
   localparam logic [2:0] ST_MEDA = 3'd3;
   localparam logic [2:0] ST_MEDB = 3'd4;
   localparam logic [2:0] ST_MEDC = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   sample_type    val_ff, val_in;
   sample_type    lo_ff, lo_in;
   sample_type    hi_ff, hi_in;
   logic          rej_ff, rej_in;
   logic          rsp_valid_ff, rsp_valid_in;
   median_type    median_ff, median_in;
   logic [CW-1:0] out_count_ff, out_count_in;
   logic          out_rej_ff, out_rej_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   sample_type    ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   sample_type    ram_rdata;

   logic          full;
   logic [EW-1:0] count_ext;

   rmed_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign full = (count_ff == CW'(CAPACITY));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      out_count_in = out_count_ff;
      out_rej_in   = out_rej_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff + AW'(1);
      ram_wdata    = val_ff;
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in = req_sample_value;
               rej_in = 1'b0;
               if (full) begin
                  rej_in   = 1'b1;
                  state_in = ST_MEDA;
               end else if (count_ff == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = req_sample_value;
                  count_in  = CW'(1);
                  state_in  = ST_MEDA;
               end else begin
                  // start the scan at the top held entry
                  ram_re    = 1'b1;
                  ram_raddr = AW'(count_ff - CW'(1));
                  ptr_in    = AW'(count_ff - CW'(1));
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (ram_rdata >= val_ff) begin
               // larger or equal entry moves up one place
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               if (ptr_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_ff - AW'(1);
                  ptr_in    = ptr_ff - AW'(1);
               end
            end else begin
               ram_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_MEDA;
            end
         end
         ST_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            count_in  = count_ff + CW'(1);
            state_in  = ST_MEDA;
         end
         ST_MEDA: begin
            // odd count reads the middle entry twice
            ram_re = 1'b1;
            if (count_ff[0]) begin
               ram_raddr = AW'(count_ff >> 1);
            end else begin
               ram_raddr = AW'((count_ff >> 1) - CW'(1));
            end
            state_in = ST_MEDB;
         end
         ST_MEDB: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(count_ff >> 1);
            lo_in     = ram_rdata;
            state_in  = ST_MEDC;
         end
         ST_MEDC: begin
            hi_in    = ram_rdata;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               median_in    = {lo_ff[SAMPLE_W-1], lo_ff} + {hi_ff[SAMPLE_W-1], hi_ff};
               out_count_in = count_ff;
               out_rej_in   = rej_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      val_ff       <= val_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rej_ff       <= rej_in;
      median_ff    <= median_in;
      out_count_ff <= out_count_in;
      out_rej_ff   <= out_rej_in;
   end

   assign count_ext = EW'(out_count_ff);

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;
   assign rsp_sample_count   = count_ext[COUNT_W-1:0];
   assign rsp_rejected_full  = out_rej_ff;

endmodule
